// ----- rtl/core/touch_selected_feedback_delay_core_defines.svh -----
// ----------------------------------------------------------------------------
// Touch delay core assertion macros
// Shared concurrent assertion forms for the touch-selected delay core.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SELECTED_FEEDBACK_DELAY_CORE_DEFINES_SVH
`define TOUCH_SELECTED_FEEDBACK_DELAY_CORE_DEFINES_SVH

// same-cycle implication
`define TSFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsfd: same-cycle check failed");

// next-cycle implication
`define TSFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsfd: next-cycle check failed");

`endif

// ----- rtl/core/tsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch delay core package
// Widths, reset values, register indexes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package tsfd_pkg;

  localparam int unsigned DelayDepthDefault = 131072;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned TouchXW  = 12;
  localparam int unsigned RegionWW = 13;
  localparam int unsigned BeatW    = 17;
  localparam int unsigned GainW    = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned ProdW    = 17;

  localparam logic [RegionWW-1:0] RegionWidthReset = 13'd270;
  localparam logic [BeatW-1:0]    BeatReset        = 17'd28235;
  localparam logic [GainW-1:0]    Fb0Reset         = 15'd16384;
  localparam logic [GainW-1:0]    Fb1Reset         = 15'd19661;
  localparam logic [GainW-1:0]    Fb2Reset         = 15'd22938;
  localparam logic [GainW-1:0]    Fb3Reset         = 15'd26214;
  localparam logic [GainW-1:0]    DryGainReset     = 15'd16384;
  localparam logic [GainW-1:0]    WetGainReset     = 15'd16384;

  // ceil(2^17 / 3): exact quotient by three for any 16 bit value
  localparam logic [16:0] Div3Recip = 17'd43691;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REGION_WIDTH = 3'd0,
    REG_BEAT         = 3'd1,
    REG_FB0          = 3'd2,
    REG_FB1          = 3'd3,
    REG_FB2          = 3'd4,
    REG_FB3          = 3'd5,
    REG_DRY_GAIN     = 3'd6,
    REG_WET_GAIN     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic latch_in;
    logic decode;
    logic edge_calc;
    logic clear_wr;
    logic set_rp;
    logic mult;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rising;
    logic clear_last;
    logic reduce_done;
  } dp_status_t;

endpackage

// ----- rtl/core/touch_selected_feedback_delay_core.sv -----
// ----------------------------------------------------------------------------
// Touch-selected feedback delay core
// Feedback delay line whose length and feedback follow the touched region.
// ----------------------------------------------------------------------------
// A sample without a touch onset holds the core from the accepting step
// through decode and store read, gain multiplies, and store write and mix;
// the result is registered at the store write and shown on the output after
// it. The step count is set by the single write port and registered read of
// the delay store. A sample that starts a touch first clears the whole store,
// one entry per cycle, before its read and later steps. The store write and
// mix stall while the previous result is still waiting on the output. After
// reset the same clearing pass runs over the whole store before the first
// sample is taken; write configuration only while no sample is in flight.
`include "touch_selected_feedback_delay_core_defines.svh"

module touch_selected_feedback_delay_core #(
  parameter int unsigned DELAY_DEPTH = tsfd_pkg::DelayDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tsfd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tsfd_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tsfd_pkg::SampleW-1:0] dry_sample_i,
  input  logic                                touch_present_i,
  input  logic [tsfd_pkg::TouchXW-1:0]        touch_x_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tsfd_pkg::SampleW-1:0] out_sample_o
);
  import tsfd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tsfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tsfd_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .dry_sample_i    (dry_sample_i),
    .touch_present_i (touch_present_i),
    .touch_x_i       (touch_x_i),
    .out_sample_o    (out_sample_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

  `TSFD_ASSERT_IMP(a_commit_slot_free, clk_i, rst_ni, cmd.commit, !out_valid_o || out_ready_i)
  `TSFD_ASSERT_NXT(a_commit_shows_result, clk_i, rst_ni, cmd.commit, out_valid_o)
  `TSFD_ASSERT_NXT(a_one_item_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `TSFD_ASSERT_IMP(a_clear_blocks_input, clk_i, rst_ni, cmd.clear_wr, !in_ready_o)

endmodule

// ----- rtl/core/tsfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Touch delay controller
// Sequences clearing passes, touch decode and the per-sample read/mix/write.
// ----------------------------------------------------------------------------
module tsfd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  tsfd_pkg::dp_status_t  status_i,
  output tsfd_pkg::ctrl_cmd_t   cmd_o
);
  import tsfd_pkg::*;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_DECODE,
    S_EDGE,
    S_CLEAR,
    S_SETRP,
    S_READ,
    S_MULT,
    S_WRITE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o           = '0;
    state_d         = state_q;
    cmd_o.latch_in  = (state_q == S_IDLE) && in_valid_i;
    case (state_q)
      S_BOOT: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = status_i.rising ? S_EDGE : S_MULT;
      end
      S_EDGE: begin
        cmd_o.edge_calc = 1'b1;
        state_d         = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (status_i.clear_last && status_i.reduce_done) begin
          state_d = S_SETRP;
        end
      end
      S_SETRP: begin
        cmd_o.set_rp = 1'b1;
        state_d      = S_READ;
      end
      S_READ: begin
        state_d = S_MULT;
      end
      S_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_BOOT;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/tsfd_datapath.sv -----
// ----------------------------------------------------------------------------
// Touch delay datapath
// Configuration registers, delay store, positions, gains and saturating mix.
// ----------------------------------------------------------------------------
module tsfd_datapath #(
  parameter int unsigned DELAY_DEPTH = tsfd_pkg::DelayDepthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tsfd_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [tsfd_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic signed [tsfd_pkg::SampleW-1:0]   dry_sample_i,
  input  logic                                  touch_present_i,
  input  logic [tsfd_pkg::TouchXW-1:0]          touch_x_i,
  output logic signed [tsfd_pkg::SampleW-1:0]   out_sample_o,
  input  tsfd_pkg::ctrl_cmd_t                   cmd_i,
  output tsfd_pkg::dp_status_t                  status_o
);
  import tsfd_pkg::*;

  localparam int unsigned AW = $clog2(DELAY_DEPTH);
  localparam int unsigned CW = (AW + 1 > BeatW) ? AW + 1 : BeatW;
  localparam logic [AW-1:0] LastPos = AW'(DELAY_DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DELAY_DEPTH);

  function automatic logic signed [ProdW-1:0] gain_q15(
    input logic [GainW-1:0] g,
    input logic signed [SampleW-1:0] x
  );
    logic signed [2*SampleW-1:0] p;
    p = $signed({1'b0, g}) * x;
    return p[2*SampleW-1:GainW];
  endfunction

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [ProdW:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

  logic [RegionWW-1:0] region_width_q;
  logic [BeatW-1:0]    beat_q;
  logic [GainW-1:0]    fb_reg_q [4];
  logic [GainW-1:0]    dry_gain_q, wet_gain_q;

  logic signed [SampleW-1:0] sample_q;
  logic                      touch_q;
  logic [TouchXW-1:0]        tx_q;

  logic                      touch_prev_q, wet_on_q;
  logic [GainW-1:0]          active_fb_q;
  logic [1:0]                region_q, region_d;
  logic [BeatW-1:0]          delay_q;
  logic [AW-1:0]             write_pos_q, read_pos_q, clear_idx_q;
  logic signed [ProdW-1:0]   dry_q, fb_prod_q, wet_prod_q;
  logic signed [SampleW-1:0] rd_data_q, out_q;

  logic signed [SampleW-1:0] mem [DELAY_DEPTH];
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [SampleW-1:0] mem_wdata;

  logic [RegionWW:0]   w2;
  logic [RegionWW+1:0] w3;
  logic [32:0]         third_prod;
  logic [BeatW-1:0]    quot;
  logic [CW-1:0]       delay_ext, wp_ext, rp_new;
  logic signed [ProdW:0] fb_sum, out_sum;
  logic signed [ProdW-1:0] wet_term;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_width_q <= RegionWidthReset;
      beat_q         <= BeatReset;
      fb_reg_q[0]    <= Fb0Reset;
      fb_reg_q[1]    <= Fb1Reset;
      fb_reg_q[2]    <= Fb2Reset;
      fb_reg_q[3]    <= Fb3Reset;
      dry_gain_q     <= DryGainReset;
      wet_gain_q     <= WetGainReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_REGION_WIDTH: region_width_q <= cfg_data_i[RegionWW-1:0];
        REG_BEAT:         beat_q         <= cfg_data_i[BeatW-1:0];
        REG_FB0:          fb_reg_q[0]    <= cfg_data_i[GainW-1:0];
        REG_FB1:          fb_reg_q[1]    <= cfg_data_i[GainW-1:0];
        REG_FB2:          fb_reg_q[2]    <= cfg_data_i[GainW-1:0];
        REG_FB3:          fb_reg_q[3]    <= cfg_data_i[GainW-1:0];
        REG_DRY_GAIN:     dry_gain_q     <= cfg_data_i[GainW-1:0];
        REG_WET_GAIN:     wet_gain_q     <= cfg_data_i[GainW-1:0];
        default:          ;
      endcase
    end
  end

  // region = min(x / width, 3) by compares against width, 2x and 3x
  always_comb begin
    w2 = {region_width_q, 1'b0};
    w3 = {1'b0, w2} + (RegionWW+2)'(region_width_q);
    if ((RegionWW+2)'(tx_q) >= w3) begin
      region_d = 2'd3;
    end else if ((RegionWW+1)'(tx_q) >= w2) begin
      region_d = 2'd2;
    end else if (RegionWW'(tx_q) >= region_width_q) begin
      region_d = 2'd1;
    end else begin
      region_d = 2'd0;
    end
  end

  always_comb begin
    third_prod = 33'(beat_q[BeatW-1:1]) * 33'(Div3Recip);
    case (region_q)
      2'd0:    quot = beat_q;
      2'd1:    quot = {1'b0, beat_q[BeatW-1:1]};
      2'd2:    quot = {2'b0, beat_q[BeatW-1:2]};
      default: quot = {1'b0, third_prod[32:17]};
    endcase
  end

  always_comb begin
    delay_ext = CW'(delay_q);
    wp_ext    = CW'(write_pos_q);
    if (wp_ext >= delay_ext) begin
      rp_new = wp_ext - delay_ext;
    end else begin
      rp_new = wp_ext + DepthC - delay_ext;
    end
  end

  always_comb begin
    wet_term = wet_on_q ? wet_prod_q : '0;
    fb_sum   = {dry_q[ProdW-1], dry_q} + {fb_prod_q[ProdW-1], fb_prod_q};
    out_sum  = {dry_q[ProdW-1], dry_q} + {wet_term[ProdW-1], wet_term};
  end

  always_comb begin
    mem_we    = cmd_i.clear_wr || cmd_i.commit;
    mem_waddr = cmd_i.clear_wr ? clear_idx_q : write_pos_q;
    mem_wdata = cmd_i.clear_wr ? '0 : sat16(fb_sum);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[read_pos_q];
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      sample_q <= dry_sample_i;
      touch_q  <= touch_present_i;
      tx_q     <= touch_x_i;
    end
    if (cmd_i.decode) begin
      dry_q    <= touch_q ? gain_q15(dry_gain_q, sample_q) : '0;
      region_q <= region_d;
    end
    if (cmd_i.edge_calc) begin
      delay_q <= quot;
    end else if (cmd_i.clear_wr && delay_ext >= DepthC) begin
      delay_q <= BeatW'(delay_ext - DepthC);
    end
    if (cmd_i.mult) begin
      fb_prod_q  <= gain_q15(active_fb_q, rd_data_q);
      wet_prod_q <= gain_q15(wet_gain_q, rd_data_q);
    end
    if (cmd_i.commit) begin
      out_q <= sat16(out_sum);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_prev_q <= 1'b0;
      wet_on_q     <= 1'b0;
      active_fb_q  <= Fb0Reset;
      write_pos_q  <= '0;
      read_pos_q   <= '0;
      clear_idx_q  <= '0;
    end else begin
      if (cmd_i.decode) begin
        touch_prev_q <= touch_q;
        if (touch_q) begin
          wet_on_q <= 1'b0;
        end else if (touch_prev_q) begin
          wet_on_q <= 1'b1;
        end
      end
      if (cmd_i.edge_calc) begin
        active_fb_q <= fb_reg_q[region_q];
      end
      if (cmd_i.clear_wr) begin
        clear_idx_q <= (clear_idx_q == LastPos) ? '0 : clear_idx_q + 1'b1;
      end
      if (cmd_i.set_rp) begin
        read_pos_q <= rp_new[AW-1:0];
      end
      if (cmd_i.commit) begin
        write_pos_q <= (write_pos_q == LastPos) ? '0 : write_pos_q + 1'b1;
        read_pos_q  <= (read_pos_q == LastPos) ? '0 : read_pos_q + 1'b1;
      end
    end
  end

  assign status_o.rising      = touch_q && !touch_prev_q;
  assign status_o.clear_last  = (clear_idx_q == LastPos);
  assign status_o.reduce_done = (delay_ext < DepthC);
  assign out_sample_o         = out_q;

endmodule
